[rtl/mi3_pkg.sv]
`default_nettype none
// ============================================================================
// mi3_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse core.
// ============================================================================
package mi3_pkg;

    localparam int unsigned NUM_ELEMS    = 9;
    localparam int unsigned FRONT_STAGES = 6;

    // Element indices a..i map to 0..8, row-major.
    // Adjugate entry k = elem[src0] * elem[src1] - elem[src2] * elem[src3].
    localparam int ADJ_SRC [NUM_ELEMS][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic valid;
        logic zero;
    } mi3_ctrl_t;

endpackage
`default_nettype wire

[rtl/mi3_front.sv]
`default_nettype none
// ============================================================================
// mi3_front
// Six-stage front end: adjugate entries, determinant by first-row cofactor
// expansion, then magnitudes and quotient signs for the divide lanes.
// ============================================================================
module mi3_front import mi3_pkg::*; #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   elem_i [NUM_ELEMS],
    output mi3_ctrl_t             ctrl_o,
    output logic [2*W:0]          num_mag_o [NUM_ELEMS],
    output logic [NUM_ELEMS-1:0]  num_neg_o,
    output logic [3*W+1:0]        den_mag_o
);

    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 2;

    logic [FRONT_STAGES-1:0] vld_reg;

    logic signed [PW-1:0] pa_reg   [NUM_ELEMS];
    logic signed [PW-1:0] pb_reg   [NUM_ELEMS];
    logic signed [W-1:0]  row1_reg [3];
    logic signed [AW-1:0] adj2_reg [NUM_ELEMS];
    logic signed [W-1:0]  row2_reg [3];
    logic signed [AW-1:0] adj3_reg [NUM_ELEMS];
    logic signed [AW-1:0] pl3_reg  [3];
    logic signed [AW-1:0] ph3_reg  [3];
    logic signed [AW-1:0] adj4_reg [NUM_ELEMS];
    logic signed [DW-1:0] term4_reg [3];
    logic signed [AW-1:0] adj5_reg [NUM_ELEMS];
    logic signed [DW-1:0] det5_reg;
    logic [AW-1:0]        mag6_reg [NUM_ELEMS];
    logic [NUM_ELEMS-1:0] neg6_reg;
    logic [DW-1:0]        den6_reg;
    logic                 zero6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_ELEMS; k++) begin
                pa_reg[k]   <= PW'(elem_i[ADJ_SRC[k][0]]) * PW'(elem_i[ADJ_SRC[k][1]]);
                pb_reg[k]   <= PW'(elem_i[ADJ_SRC[k][2]]) * PW'(elem_i[ADJ_SRC[k][3]]);
                adj2_reg[k] <= AW'(pa_reg[k]) - AW'(pb_reg[k]);
                adj3_reg[k] <= adj2_reg[k];
                adj4_reg[k] <= adj3_reg[k];
                adj5_reg[k] <= adj4_reg[k];
                mag6_reg[k] <= adj5_reg[k][AW-1] ? AW'(-adj5_reg[k]) : AW'(adj5_reg[k]);
                neg6_reg[k] <= adj5_reg[k][AW-1] ^ det5_reg[DW-1];
            end
            for (int j = 0; j < 3; j++) begin
                row1_reg[j]  <= elem_i[j];
                row2_reg[j]  <= row1_reg[j];
                // Cofactor split into an unsigned low word and a signed high part.
                pl3_reg[j]   <= AW'(row2_reg[j]) * AW'($signed({1'b0, adj2_reg[3*j][W-1:0]}));
                ph3_reg[j]   <= AW'(row2_reg[j]) * AW'($signed(adj2_reg[3*j][AW-1:W]));
                term4_reg[j] <= (DW'(ph3_reg[j]) <<< W) + DW'(pl3_reg[j]);
            end
            det5_reg  <= term4_reg[0] + term4_reg[1] + term4_reg[2];
            den6_reg  <= det5_reg[DW-1] ? DW'(-det5_reg) : DW'(det5_reg);
            zero6_reg <= (det5_reg == '0);
        end
    end

    assign ctrl_o    = '{valid: vld_reg[FRONT_STAGES-1], zero: zero6_reg};
    assign num_mag_o = mag6_reg;
    assign num_neg_o = neg6_reg;
    assign den_mag_o = den6_reg;

endmodule
`default_nettype wire

[rtl/mi3_div_lane.sv]
`default_nettype none
// ============================================================================
// mi3_div_lane
// Pipelined restoring divider for one output element: one quotient bit per
// stage, followed by saturation to the signed word range and sign restore.
// ============================================================================
module mi3_div_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [2*W:0]        num_mag_i,
    input  logic                num_neg_i,
    input  logic [3*W+1:0]      den_mag_i,
    output logic signed [W-1:0] quo_o,
    output logic                sat_o
);

    localparam int DW = 3 * W + 2;
    localparam int RW = 4 * W + 3;
    localparam int QB = W + 1;

    logic [RW-1:0] n0;
    logic [RW-1:0] dsh;
    logic [RW-1:0] cand [1:QB];
    logic          ge   [1:QB];

    logic [RW-1:0] rem_reg [0:QB-1];
    logic [DW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] quo_reg [0:QB];
    logic          neg_reg [0:QB];
    logic          ov_reg  [0:QB];

    logic [QB-1:0] lim;
    logic [QB-1:0] qs;
    logic          sat;

    logic signed [W-1:0] quo_out_reg;
    logic                sat_out_reg;

    assign n0  = RW'(num_mag_i) << (2 * F);
    assign dsh = RW'(den_mag_i) << QB;

    always_comb begin
        for (int s = 1; s <= QB; s++) begin
            cand[s] = RW'(den_reg[s-1]) << (QB - s);
            ge[s]   = (rem_reg[s-1] >= cand[s]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= n0;
            den_reg[0] <= den_mag_i;
            quo_reg[0] <= '0;
            neg_reg[0] <= num_neg_i;
            // A quotient of 2^(W+1) or more always saturates.
            ov_reg[0]  <= (n0 >= dsh);
            for (int s = 1; s < QB; s++) begin
                rem_reg[s] <= ge[s] ? rem_reg[s-1] - cand[s] : rem_reg[s-1];
                den_reg[s] <= den_reg[s-1];
            end
            for (int s = 1; s <= QB; s++) begin
                quo_reg[s] <= quo_reg[s-1] | (QB'(ge[s]) << (QB - s));
                neg_reg[s] <= neg_reg[s-1];
                ov_reg[s]  <= ov_reg[s-1];
            end
            sat_out_reg <= sat;
            quo_out_reg <= neg_reg[QB] ? -qs[W-1:0] : qs[W-1:0];
        end
    end

    always_comb begin
        lim = (QB'(1) << (W - 1)) - QB'(!neg_reg[QB]);
        sat = ov_reg[QB] || (quo_reg[QB] > lim);
        qs  = sat ? lim : quo_reg[QB];
    end

    assign quo_o = quo_out_reg;
    assign sat_o = sat_out_reg;

endmodule
`default_nettype wire

[rtl/mi3_out_buf.sv]
`default_nettype none
// ============================================================================
// mi3_out_buf
// Two-entry output buffer that decouples the pipeline from the result port.
// ============================================================================
module mi3_out_buf #(
    parameter int DATA_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [DATA_BITS-1:0] in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] out_data
);

    logic [1:0]           count_reg, count_next;
    logic [DATA_BITS-1:0] head_reg, head_next;
    logic [DATA_BITS-1:0] skid_reg, skid_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        unique case (count_reg)
            2'd0: begin
                if (push) begin
                    head_next  = in_data;
                    count_next = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = in_data;
                end else if (push) begin
                    skid_next  = in_data;
                    count_next = 2'd2;
                end else if (pop) begin
                    count_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next  = skid_reg;
                    count_next = 2'd1;
                end
            end
            default: begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule
`default_nettype wire

[rtl/matrix_inverse_3x3_core.sv]
`default_nettype none
// ============================================================================
// matrix_inverse_3x3_core
// Inverse of a signed fixed-point 3x3 matrix through the adjugate and an
// exact determinant, with truncating division and saturation.
// ============================================================================
//
//  Channel   Ports              Beat contents
//  input     s_valid/s_ready    s_m00 .. s_m22, matrix row by row
//  result    m_valid/m_ready    m_r00 .. m_r22, m_singular, m_saturated
//
// One matrix is taken every cycle while s_ready is high; a result beat passes
// through six front-end stages, WORD_BITS + 3 stages in the divide lanes,
// which resolve one quotient bit per stage, and the output buffer.
// Reset clears the valid bits of the pipeline and the output buffer.
// When the two-entry output buffer is full the whole pipeline holds and
// s_ready falls; nothing inside is lost or repeated.
//
module matrix_inverse_3x3_core import mi3_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [WORD_BITS-1:0] s_m00,
    input  logic signed [WORD_BITS-1:0] s_m01,
    input  logic signed [WORD_BITS-1:0] s_m02,
    input  logic signed [WORD_BITS-1:0] s_m10,
    input  logic signed [WORD_BITS-1:0] s_m11,
    input  logic signed [WORD_BITS-1:0] s_m12,
    input  logic signed [WORD_BITS-1:0] s_m20,
    input  logic signed [WORD_BITS-1:0] s_m21,
    input  logic signed [WORD_BITS-1:0] s_m22,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_BITS-1:0] m_r00,
    output logic signed [WORD_BITS-1:0] m_r01,
    output logic signed [WORD_BITS-1:0] m_r02,
    output logic signed [WORD_BITS-1:0] m_r10,
    output logic signed [WORD_BITS-1:0] m_r11,
    output logic signed [WORD_BITS-1:0] m_r12,
    output logic signed [WORD_BITS-1:0] m_r20,
    output logic signed [WORD_BITS-1:0] m_r21,
    output logic signed [WORD_BITS-1:0] m_r22,
    output logic                        m_singular,
    output logic                        m_saturated
);

    localparam int W         = WORD_BITS;
    localparam int LANE_LAT  = W + 3;
    localparam int DATA_BITS = NUM_ELEMS * W + 2;

    logic                  en;
    logic signed [W-1:0]   elem [NUM_ELEMS];
    mi3_ctrl_t             front_ctrl;
    logic [2*W:0]          num_mag [NUM_ELEMS];
    logic [NUM_ELEMS-1:0]  num_neg;
    logic [3*W+1:0]        den_mag;
    logic signed [W-1:0]   quo [NUM_ELEMS];
    logic [NUM_ELEMS-1:0]  lane_sat;
    mi3_ctrl_t             ctl_reg [LANE_LAT];
    logic [DATA_BITS-1:0]  buf_in;
    logic [DATA_BITS-1:0]  buf_out;

    assign elem[0] = s_m00;
    assign elem[1] = s_m01;
    assign elem[2] = s_m02;
    assign elem[3] = s_m10;
    assign elem[4] = s_m11;
    assign elem[5] = s_m12;
    assign elem[6] = s_m20;
    assign elem[7] = s_m21;
    assign elem[8] = s_m22;

    assign s_ready = en;

    mi3_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .elem_i    (elem),
        .ctrl_o    (front_ctrl),
        .num_mag_o (num_mag),
        .num_neg_o (num_neg),
        .den_mag_o (den_mag)
    );

    for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_lane
        mi3_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
            .aclk      (aclk),
            .en        (en),
            .num_mag_i (num_mag[k]),
            .num_neg_i (num_neg[k]),
            .den_mag_i (den_mag),
            .quo_o     (quo[k]),
            .sat_o     (lane_sat[k])
        );
    end

    // Valid and singular flags ride alongside the divide lanes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < LANE_LAT; s++) begin
                ctl_reg[s] <= '0;
            end
        end else if (en) begin
            ctl_reg[0] <= front_ctrl;
            for (int s = 1; s < LANE_LAT; s++) begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    always_comb begin
        buf_in    = '0;
        buf_in[1] = ctl_reg[LANE_LAT-1].zero;
        buf_in[0] = !ctl_reg[LANE_LAT-1].zero && (|lane_sat);
        for (int k = 0; k < NUM_ELEMS; k++) begin
            buf_in[2 + k*W +: W] = ctl_reg[LANE_LAT-1].zero ? '0 : quo[k];
        end
    end

    mi3_out_buf #(.DATA_BITS(DATA_BITS)) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ctl_reg[LANE_LAT-1].valid),
        .in_data   (buf_in),
        .in_ready  (en),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (buf_out)
    );

    assign m_saturated = buf_out[0];
    assign m_singular  = buf_out[1];
    assign m_r00 = buf_out[2 + 0*W +: W];
    assign m_r01 = buf_out[2 + 1*W +: W];
    assign m_r02 = buf_out[2 + 2*W +: W];
    assign m_r10 = buf_out[2 + 3*W +: W];
    assign m_r11 = buf_out[2 + 4*W +: W];
    assign m_r12 = buf_out[2 + 5*W +: W];
    assign m_r20 = buf_out[2 + 6*W +: W];
    assign m_r21 = buf_out[2 + 7*W +: W];
    assign m_r22 = buf_out[2 + 8*W +: W];

`ifndef NO_ASSERTIONS
    a_singular_not_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> !m_saturated)
        else $error("singular result also flagged as saturated");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> (m_r00 == '0 && m_r11 == '0 && m_r22 == '0))
        else $error("singular result carries non-zero elements");

    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input held off with no result waiting");
`endif

endmodule
`default_nettype wire
